[src/mmpq_pkg.sv]
// Shared types, constants and helpers for the MIDI message parser queue.
package mmpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int PEND_W      = 5;
  localparam int LOST_W      = 8;

  localparam int CQ_DEPTH    = 2;
  localparam int CQ_IDX_W    = $clog2(CQ_DEPTH);
  localparam int CQ_CNT_W    = $clog2(CQ_DEPTH + 1);

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_DEQUEUE = 1'b1;

  typedef struct packed {
    logic [7:0] status;
    logic [7:0] data1;
    logic [7:0] data2;
    logic [1:0] length;
  } msg_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH,
    OP_POP
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t op;
    msg_t    msg;
  } cmd_t;

  function automatic logic [1:0] status_length(input logic [7:0] b);
    logic [1:0] len;
    priority if (b < 8'h80)                len = 2'd1;
    else if (b < 8'hC0)                    len = 2'd3;
    else if (b < 8'hE0)                    len = 2'd2;
    else if (b < 8'hF0)                    len = 2'd3;
    else if (b == 8'hF1 || b == 8'hF3)     len = 2'd2;
    else if (b == 8'hF2)                   len = 2'd3;
    else                                   len = 2'd1;
    return len;
  endfunction

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

endpackage

[src/mmpq_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface mmpq_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source(output valid, kind, data_byte, input ready);
  modport sink(input valid, kind, data_byte, output ready);
endinterface

interface mmpq_out_if;
  logic       valid;
  logic       ready;
  logic       msg_valid;
  logic [7:0] msg_status;
  logic [7:0] msg_data1;
  logic [7:0] msg_data2;
  logic [1:0] msg_length;
  logic [4:0] pending_count;
  logic [7:0] lost_count;

  modport source(output valid, msg_valid, msg_status, msg_data1, msg_data2, msg_length,
                 pending_count, lost_count, input ready);
  modport sink(input valid, msg_valid, msg_status, msg_data1, msg_data2, msg_length,
               pending_count, lost_count, output ready);
endinterface

[src/mmpq_front.sv]
// Front end: accepts items, runs the MIDI byte parser, emits queue commands.
module mmpq_front
  import mmpq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  mmpq_in_if.sink      in_chan,
  input  logic         cq_full,
  output logic         cq_push,
  output cmd_t         cq_cmd
);

  typedef enum logic [1:0] {
    PH_STATUS,
    PH_DB1,
    PH_DB2,
    PH_SYSEX
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] status_r, status_nxt;
  logic [7:0] data1_r, data1_nxt;
  logic [1:0] length_r, length_nxt;
  logic [1:0] blen;
  logic [7:0] b;

  assign in_chan.ready = !cq_full;
  assign cq_push       = in_chan.valid && in_chan.ready;
  assign b             = in_chan.data_byte;
  assign blen          = status_length(b);

  always_comb begin
    phase_nxt  = phase_r;
    status_nxt = status_r;
    data1_nxt  = data1_r;
    length_nxt = length_r;
    cq_cmd     = '{op: OP_NONE, msg: '0};
    if (in_chan.kind == KIND_DEQUEUE) begin
      cq_cmd.op = OP_POP;
    end else begin
      unique case (phase_r)
        PH_STATUS: begin
          status_nxt = b;
          if (b == SYSEX_START) begin
            phase_nxt = PH_SYSEX;
          end else begin
            length_nxt = blen;
            if (blen > 2'd1) begin
              phase_nxt = PH_DB1;
            end else begin
              cq_cmd.op  = OP_PUSH;
              cq_cmd.msg = '{status: b, data1: 8'd0, data2: 8'd0, length: 2'd1};
            end
          end
        end
        PH_DB1: begin
          data1_nxt = b;
          if (length_r > 2'd2) begin
            phase_nxt = PH_DB2;
          end else begin
            phase_nxt  = PH_STATUS;
            cq_cmd.op  = OP_PUSH;
            cq_cmd.msg = '{status: status_r, data1: b, data2: 8'd0, length: 2'd2};
          end
        end
        PH_DB2: begin
          phase_nxt  = PH_STATUS;
          cq_cmd.op  = OP_PUSH;
          cq_cmd.msg = '{status: status_r, data1: data1_r, data2: b, length: 2'd3};
        end
        PH_SYSEX: begin
          if (b == SYSEX_END) phase_nxt = PH_STATUS;
        end
        default: phase_nxt = PH_STATUS;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_STATUS;
      status_r <= 8'd0;
      data1_r  <= 8'd0;
      length_r <= 2'd1;
    end else if (cq_push) begin
      phase_r  <= phase_nxt;
      status_r <= status_nxt;
      data1_r  <= data1_nxt;
      length_r <= length_nxt;
    end
  end

endmodule

[src/mmpq_cmd_fifo.sv]
// Short command queue between the parser front end and the message queue back end.
module mmpq_cmd_fifo
  import mmpq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                entries_r [CQ_DEPTH];
  logic [CQ_IDX_W-1:0] wr_idx_r;
  logic [CQ_IDX_W-1:0] rd_idx_r;
  logic [CQ_CNT_W-1:0] cnt_r;

  assign full    = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = entries_r[rd_idx_r];

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_idx_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r <= '0;
      rd_idx_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_idx_r <= wr_idx_r + 1'b1;
      if (pop)  rd_idx_r <= rd_idx_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[src/mmpq_back.sv]
// Back end: ring message queue with overflow drop, result output register.
module mmpq_back
  import mmpq_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cq_empty,
  input  cmd_t         cq_cmd,
  output logic         cq_pop,
  mmpq_out_if.source   out_chan
);

  msg_t              mem [QUEUE_DEPTH];
  msg_t              rd_msg_r;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [LOST_W-1:0] lost_r, lost_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              hit_r, hit_nxt;
  logic              mem_we;
  logic              mem_re;

  assign cq_pop = !cq_empty && (!out_valid_r || out_chan.ready);

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    rd_ptr_nxt    = rd_ptr_r;
    count_nxt     = count_r;
    lost_nxt      = lost_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    hit_nxt       = hit_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    if (cq_pop) begin
      out_valid_nxt = 1'b1;
      hit_nxt       = 1'b0;
      unique case (cq_cmd.op)
        OP_PUSH: begin
          mem_we     = 1'b1;
          wr_ptr_nxt = next_ptr(wr_ptr_r);
          if (count_r == CNT_W'(QUEUE_DEPTH)) begin
            rd_ptr_nxt = next_ptr(rd_ptr_r);
            lost_nxt   = lost_r + 1'b1;
          end else begin
            count_nxt = count_r + 1'b1;
          end
        end
        OP_POP: begin
          if (count_r != '0) begin
            mem_re     = 1'b1;
            hit_nxt    = 1'b1;
            rd_ptr_nxt = next_ptr(rd_ptr_r);
            count_nxt  = count_r - 1'b1;
          end
        end
        OP_NONE: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_ptr_r] <= cq_cmd.msg;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_msg_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      count_r     <= '0;
      lost_r      <= '0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      count_r     <= count_nxt;
      lost_r      <= lost_nxt;
      out_valid_r <= out_valid_nxt;
      hit_r       <= hit_nxt;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.msg_valid     = hit_r;
  assign out_chan.msg_status    = hit_r ? rd_msg_r.status : 8'd0;
  assign out_chan.msg_data1     = hit_r ? rd_msg_r.data1  : 8'd0;
  assign out_chan.msg_data2     = hit_r ? rd_msg_r.data2  : 8'd0;
  assign out_chan.msg_length    = hit_r ? rd_msg_r.length : 2'd0;
  assign out_chan.pending_count = PEND_W'(count_r);
  assign out_chan.lost_count    = lost_r;

endmodule

[src/midi_message_parser_queue_unit.sv]
// Top level of the MIDI message parser with message queue.
// Accepts one item per clock: a received MIDI byte or a dequeue request, and gives
// exactly one result per item, in order. The parser is combinational and writes a
// command straight into a two-entry command queue at the accepting edge; the queue
// back end pops it when the result register is free or being taken and loads the
// result register, so each result passes through a command queue entry and then the
// result register. Sustained rate is one item per cycle while results are taken
// each cycle, as the back end then pops one command per cycle. The input stalls only
// when a result waits and the command queue has filled behind it. No clearing pass
// after reset: the block is ready straight out of reset.
module midi_message_parser_queue_unit
  import mmpq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mmpq_in_if.sink     in_chan,
  mmpq_out_if.source  out_chan
);

  logic cq_push;
  cmd_t cq_push_cmd;
  logic cq_full;
  logic cq_pop;
  cmd_t cq_pop_cmd;
  logic cq_empty;

  mmpq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cq_full (cq_full),
    .cq_push (cq_push),
    .cq_cmd  (cq_push_cmd)
  );

  mmpq_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (cq_push),
    .push_cmd (cq_push_cmd),
    .full     (cq_full),
    .pop      (cq_pop),
    .pop_cmd  (cq_pop_cmd),
    .empty    (cq_empty)
  );

  mmpq_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cq_empty (cq_empty),
    .cq_cmd   (cq_pop_cmd),
    .cq_pop   (cq_pop),
    .out_chan (out_chan)
  );

  a_msg_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.msg_valid |-> out_chan.msg_length != 2'd0)
    else $error("dequeued message with zero length");

  a_dequeue_leaves_room: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.msg_valid |-> out_chan.pending_count < PEND_W'(QUEUE_DEPTH))
    else $error("pending count too high after dequeue");

  a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with no result waiting");

endmodule
